// ===== rtl/hrhp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_pkg
// types, character codes and the key table shared by the request header parser
// ----------------------------------------------------------------------------
package hrhp_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int CL_W            = 32;
    localparam int KEY_LEN         = 14;
    localparam int KEY_POS_W       = 4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [3:0] {
        PH_CONTENT      = 4'd0,
        PH_METHOD       = 4'd1,
        PH_URI          = 4'd2,
        PH_PROTO        = 4'd3,
        PH_EXP_LF       = 4'd4,
        PH_SKIP_SP      = 4'd5,
        PH_KEY          = 4'd6,
        PH_VALUE        = 4'd7,
        PH_EXP_FINAL_LF = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        CLS_DELIM   = 3'd0,
        CLS_METHOD  = 3'd1,
        CLS_URI     = 3'd2,
        CLS_PROTO   = 3'd3,
        CLS_KEY     = 3'd4,
        CLS_VALUE   = 3'd5,
        CLS_CONTENT = 3'd6,
        CLS_IGNORED = 3'd7
    } t_class;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       chunk_last;
    } t_req_item;

    typedef struct packed {
        logic [7:0]      byte_out;
        logic [2:0]      byte_class;
        logic            field_end;
        logic            header_done;
        logic            parse_error;
        logic [CL_W-1:0] content_length;
    } t_rsp_item;

    // characters of the key "Content-Length"
    function automatic logic [7:0] key_char(input logic [KEY_POS_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h4C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/hrhp_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_req_if
// request byte channel: valid, ready and one byte item
// ----------------------------------------------------------------------------
interface hrhp_req_if import hrhp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_req_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/hrhp_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_rsp_if
// result channel: valid, ready and one tagged byte item
// ----------------------------------------------------------------------------
interface hrhp_rsp_if import hrhp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_rsp_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/hrhp_digit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_digit
// one decimal step of the length accumulator, saturating multiply by ten
// ----------------------------------------------------------------------------
module hrhp_digit import hrhp_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic [LENGTH_BITS-1:0] i_acc,
    input  logic                   i_stopped,
    input  logic                   i_enable,
    input  logic                   i_first,
    input  logic [7:0]             i_byte,
    output logic [LENGTH_BITS-1:0] o_acc,
    output logic                   o_stopped
);

    logic [LENGTH_BITS+3:0] w_ext;
    logic [LENGTH_BITS+3:0] w_prod;
    logic [3:0]             w_digit;
    logic [7:0]             w_diff;

    assign w_diff  = i_byte - CH_ZERO;
    assign w_digit = w_diff[3:0];
    assign w_ext   = {4'b0, i_acc};
    // acc * 10 + d as two shifts and two adds
    assign w_prod  = (w_ext << 3) + (w_ext << 1) + (LENGTH_BITS+4)'(w_digit);

    always_comb begin
        o_acc     = i_acc;
        o_stopped = i_stopped;
        if (i_enable && !i_stopped) begin
            if (i_byte inside {[CH_ZERO:CH_NINE]}) begin
                if (|w_prod[LENGTH_BITS+3:LENGTH_BITS]) begin
                    o_acc = '1;
                end else begin
                    o_acc = w_prod[LENGTH_BITS-1:0];
                end
            end else if (i_first && i_byte == CH_PLUS) begin
                o_stopped = i_stopped;
            end else begin
                o_stopped = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/hrhp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_core
// parser state and the per-byte classification of one registered item
// ----------------------------------------------------------------------------
module hrhp_core import hrhp_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_req_item i_item,
    output t_rsp_item o_result
);

    t_phase                 r_phase,    n_phase;
    logic                   r_key_has,  n_key_has;
    logic [KEY_POS_W-1:0]   r_key_pos,  n_key_pos;
    logic                   r_key_miss, n_key_miss;
    logic [LENGTH_BITS-1:0] r_acc,      n_acc;
    logic                   r_stopped,  n_stopped;
    logic [LENGTH_BITS-1:0] r_length,   n_length;
    logic                   r_skip,     n_skip;
    logic                   r_error,    n_error;

    logic                   w_is_len;
    logic [LENGTH_BITS-1:0] w_dig_acc;
    logic                   w_dig_stopped;
    logic [7:0]             w_b;
    t_class                 w_cls;
    logic                   w_fend;

    assign w_b      = i_item.byte_in;
    assign w_is_len = !r_key_miss && (r_key_pos == KEY_POS_W'(KEY_LEN));

    hrhp_digit #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_digit (
        .i_acc     (r_acc),
        .i_stopped (r_stopped),
        .i_enable  (w_is_len),
        .i_first   (r_phase == PH_SKIP_SP),
        .i_byte    (w_b),
        .o_acc     (w_dig_acc),
        .o_stopped (w_dig_stopped)
    );

    always_comb begin
        n_phase    = r_phase;
        n_key_has  = r_key_has;
        n_key_pos  = r_key_pos;
        n_key_miss = r_key_miss;
        n_acc      = r_acc;
        n_stopped  = r_stopped;
        n_length   = r_length;
        n_skip     = r_skip;
        n_error    = r_error;
        w_cls      = CLS_IGNORED;
        w_fend     = 1'b0;

        if (r_error) begin
            w_cls = CLS_IGNORED;
        end else if (r_skip) begin
            if (i_item.chunk_last) begin
                n_skip = 1'b0;
            end
        end else if (w_b == CH_NUL) begin
            n_skip = !i_item.chunk_last;
        end else begin
            case (r_phase)
                PH_METHOD: begin
                    if (w_b == CH_SP) begin
                        n_phase = PH_URI;
                        w_cls   = CLS_DELIM;
                        w_fend  = 1'b1;
                    end else begin
                        w_cls = CLS_METHOD;
                    end
                end
                PH_URI: begin
                    if (w_b == CH_SP) begin
                        n_phase = PH_PROTO;
                        w_cls   = CLS_DELIM;
                        w_fend  = 1'b1;
                    end else begin
                        w_cls = CLS_URI;
                    end
                end
                PH_PROTO: begin
                    if (w_b == CH_CR) begin
                        n_phase = PH_EXP_LF;
                        w_cls   = CLS_DELIM;
                        w_fend  = 1'b1;
                    end else begin
                        w_cls = CLS_PROTO;
                    end
                end
                PH_EXP_LF: begin
                    if (w_b == CH_LF) begin
                        n_phase    = PH_KEY;
                        w_cls      = CLS_DELIM;
                        n_key_has  = 1'b0;
                        n_key_pos  = '0;
                        n_key_miss = 1'b0;
                    end else begin
                        n_error = 1'b1;
                    end
                end
                PH_KEY: begin
                    if (w_b == CH_COLON) begin
                        n_phase   = PH_SKIP_SP;
                        w_cls     = CLS_DELIM;
                        w_fend    = 1'b1;
                        n_acc     = '0;
                        n_stopped = 1'b0;
                    end else if (w_b == CH_CR) begin
                        // blank line ends the header, cr inside a key is malformed
                        if (r_key_has) begin
                            n_error = 1'b1;
                        end else begin
                            n_phase = PH_EXP_FINAL_LF;
                            w_cls   = CLS_DELIM;
                        end
                    end else begin
                        w_cls     = CLS_KEY;
                        n_key_has = 1'b1;
                        if (r_key_pos < KEY_POS_W'(KEY_LEN) && w_b == key_char(r_key_pos)) begin
                            n_key_pos = r_key_pos + 1'b1;
                        end else begin
                            n_key_miss = 1'b1;
                        end
                    end
                end
                PH_SKIP_SP: begin
                    if (w_b == CH_SP) begin
                        w_cls = CLS_DELIM;
                    end else begin
                        w_cls     = CLS_VALUE;
                        n_phase   = PH_VALUE;
                        n_acc     = w_dig_acc;
                        n_stopped = w_dig_stopped;
                    end
                end
                PH_VALUE: begin
                    if (w_b == CH_CR) begin
                        w_cls   = CLS_DELIM;
                        w_fend  = 1'b1;
                        n_phase = PH_EXP_LF;
                        if (w_is_len) begin
                            n_length = r_acc;
                        end
                        n_key_has  = 1'b0;
                        n_key_pos  = '0;
                        n_key_miss = 1'b0;
                    end else begin
                        w_cls     = CLS_VALUE;
                        n_acc     = w_dig_acc;
                        n_stopped = w_dig_stopped;
                    end
                end
                PH_EXP_FINAL_LF: begin
                    if (w_b == CH_LF) begin
                        n_phase = PH_CONTENT;
                        w_cls   = CLS_DELIM;
                    end else begin
                        n_error = 1'b1;
                    end
                end
                PH_CONTENT: begin
                    w_cls = CLS_CONTENT;
                end
                default: begin
                    w_cls = CLS_IGNORED;
                end
            endcase
        end
    end

    always_comb begin
        o_result.byte_out    = w_b;
        o_result.byte_class  = w_cls;
        o_result.field_end   = w_fend;
        o_result.header_done = (n_phase == PH_CONTENT);
        o_result.parse_error = n_error;
        // saturate to the reported width when the accumulator is wider
        if (LENGTH_BITS > CL_W && n_length > LENGTH_BITS'({CL_W{1'b1}})) begin
            o_result.content_length = '1;
        end else begin
            o_result.content_length = CL_W'(n_length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_METHOD;
            r_key_has  <= 1'b0;
            r_key_pos  <= '0;
            r_key_miss <= 1'b0;
            r_acc      <= '0;
            r_stopped  <= 1'b0;
            r_length   <= '0;
            r_skip     <= 1'b0;
            r_error    <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_key_has  <= n_key_has;
            r_key_pos  <= n_key_pos;
            r_key_miss <= n_key_miss;
            r_acc      <= n_acc;
            r_stopped  <= n_stopped;
            r_length   <= n_length;
            r_skip     <= n_skip;
            r_error    <= n_error;
        end
    end

endmodule

// ===== rtl/http_request_header_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_header_parser_unit
// one-byte-per-item request line and header parser with content-length pickup
// ----------------------------------------------------------------------------
// usage
//   i_req carries one raw request byte per item plus a chunk-last flag
//   o_rsp returns one item per request byte: the byte, its class, field end,
//   header done, sticky parse error and the latest content-length value
//   both channels use valid/ready, an item moves when both are high
// timing
//   an accepted byte is held in the input register and parsed from there; its
//   result is stored in the output register, which drives it valid on o_rsp
//   throughput is one byte per cycle unless o_rsp stalls, set by the single
//   decimal step (shift-add multiply by ten) between the input and output registers
// reset
//   synchronous active-low; both registers empty, parser back in the method
//   phase, length cleared, error and chunk skip cleared
// back-pressure
//   when o_rsp stalls, the held input byte waits and i_req.ready drops once
//   the input register is full too; nothing is lost or repeated
// ----------------------------------------------------------------------------
module http_request_header_parser_unit import hrhp_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hrhp_req_if.sink          i_req,
    hrhp_rsp_if.source        o_rsp
);

    // input register
    logic      r_in_valid;
    t_req_item r_in_item;

    // output register
    logic      r_out_valid;
    t_rsp_item r_out_item;

    logic      w_out_free;
    logic      w_step;
    t_rsp_item w_result;

    // the output slot frees when empty or being taken this cycle
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    // the held byte is parsed and state advances only when its result can be stored
    assign w_step      = r_in_valid && w_out_free;
    assign i_req.ready = !r_in_valid || w_step;

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_item;

    hrhp_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_out_free) begin
                r_out_valid <= w_step;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_item <= i_req.data;
        end
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the request header parser: one request line, a long
// run of random header lines (length keys, near misses, odd values), NUL
// chunks, then a body or a broken line ending; every result item is checked
// against a byte-level predictor
// ----------------------------------------------------------------------------
module tb;
    import hrhp_pkg::*;

    localparam int          ITEM_TARGET = 2000;
    localparam int          BODY_ITEMS  = 400;
    localparam int          QUIET_TAIL  = 150;
    localparam int          DRAIN_WAIT  = 16;
    localparam int          MAX_REPORTS = 10;
    localparam longint unsigned TIMEOUT_NS = 64'd5_000_000;

    localparam longint unsigned LEN_MAX = (LENGTH_BITS_DEF >= 64) ?
        64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << LENGTH_BITS_DEF) - 64'd1);
    localparam logic [8*KEY_LEN-1:0] LENGTH_KEY = "Content-Length";

    typedef enum int {
        END_BODY,
        END_BAD_LF,
        END_KEY_CR,
        END_BAD_FINAL_LF
    } t_ending;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hrhp_req_if req_ch ();
    hrhp_rsp_if rsp_ch ();

    http_request_header_parser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_req_item pending_bytes[$];
    t_rsp_item expected_tags[$];
    int        mismatch_count = 0;
    int        send_hold = 0;
    int        take_hold = 0;
    t_rsp_item want_rsp;

    // predictor state, reset values
    t_phase          phase_now   = PH_METHOD;
    logic            key_started = 1'b0;
    int unsigned     key_hits    = 0;
    logic            key_broken  = 1'b0;
    longint unsigned value_acc   = 0;
    logic            value_done  = 1'b0;
    longint unsigned length_seen = 0;
    logic            chunk_skip  = 1'b0;
    logic            error_seen  = 1'b0;

    function automatic logic [7:0] length_key_char(input int unsigned pos);
        return LENGTH_KEY[8*(KEY_LEN-1-pos) +: 8];
    endfunction

    function automatic logic length_key();
        return !key_broken && key_hits == KEY_LEN;
    endfunction

    function automatic void forget_key();
        key_started = 1'b0;
        key_hits    = 0;
        key_broken  = 1'b0;
    endfunction

    // decimal pickup of a length value, saturating
    function automatic void feed_length_digit(input logic [7:0] b, input logic first);
        longint unsigned d;
        if (!length_key() || value_done)
            return;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            d = 64'(b) - 64'(CH_ZERO);
            if (value_acc > (LEN_MAX - d) / 10)
                value_acc = LEN_MAX;
            else
                value_acc = value_acc * 10 + d;
        end else if (!(first && b == CH_PLUS)) begin
            value_done = 1'b1;
        end
    endfunction

    // tag one byte and advance the parse state
    function automatic t_rsp_item parse_byte(input t_req_item it);
        logic [7:0] b;
        t_class     cls;
        logic       fend;
        t_rsp_item  r;
        b    = it.byte_in;
        cls  = CLS_IGNORED;
        fend = 1'b0;
        if (!error_seen) begin
            if (chunk_skip) begin
                if (it.chunk_last)
                    chunk_skip = 1'b0;
            end else if (b == CH_NUL) begin
                chunk_skip = !it.chunk_last;
            end else begin
                case (phase_now)
                    PH_METHOD: begin
                        if (b == CH_SP) begin
                            phase_now = PH_URI;
                            cls = CLS_DELIM;
                            fend = 1'b1;
                        end else begin
                            cls = CLS_METHOD;
                        end
                    end
                    PH_URI: begin
                        if (b == CH_SP) begin
                            phase_now = PH_PROTO;
                            cls = CLS_DELIM;
                            fend = 1'b1;
                        end else begin
                            cls = CLS_URI;
                        end
                    end
                    PH_PROTO: begin
                        if (b == CH_CR) begin
                            phase_now = PH_EXP_LF;
                            cls = CLS_DELIM;
                            fend = 1'b1;
                        end else begin
                            cls = CLS_PROTO;
                        end
                    end
                    PH_EXP_LF: begin
                        if (b == CH_LF) begin
                            phase_now = PH_KEY;
                            cls = CLS_DELIM;
                            forget_key();
                        end else begin
                            error_seen = 1'b1;
                        end
                    end
                    PH_KEY: begin
                        if (b == CH_COLON) begin
                            phase_now = PH_SKIP_SP;
                            cls = CLS_DELIM;
                            fend = 1'b1;
                            value_acc = 0;
                            value_done = 1'b0;
                        end else if (b == CH_CR) begin
                            if (key_started) begin
                                error_seen = 1'b1;
                            end else begin
                                phase_now = PH_EXP_FINAL_LF;
                                cls = CLS_DELIM;
                            end
                        end else begin
                            cls = CLS_KEY;
                            key_started = 1'b1;
                            if (key_hits < KEY_LEN && b == length_key_char(key_hits))
                                key_hits++;
                            else
                                key_broken = 1'b1;
                        end
                    end
                    PH_SKIP_SP: begin
                        if (b == CH_SP) begin
                            cls = CLS_DELIM;
                        end else begin
                            cls = CLS_VALUE;
                            phase_now = PH_VALUE;
                            feed_length_digit(b, 1'b1);
                        end
                    end
                    PH_VALUE: begin
                        if (b == CH_CR) begin
                            cls = CLS_DELIM;
                            fend = 1'b1;
                            phase_now = PH_EXP_LF;
                            if (length_key())
                                length_seen = value_acc;
                            forget_key();
                        end else begin
                            cls = CLS_VALUE;
                            feed_length_digit(b, 1'b0);
                        end
                    end
                    PH_EXP_FINAL_LF: begin
                        if (b == CH_LF) begin
                            phase_now = PH_CONTENT;
                            cls = CLS_DELIM;
                        end else begin
                            error_seen = 1'b1;
                        end
                    end
                    PH_CONTENT: cls = CLS_CONTENT;
                    default:    cls = CLS_IGNORED;
                endcase
            end
        end
        r.byte_out       = b;
        r.byte_class     = cls;
        r.field_end      = fend;
        r.header_done    = (phase_now == PH_CONTENT);
        r.parse_error    = error_seen;
        r.content_length = (length_seen > 64'hFFFF_FFFF) ? '1 : length_seen[CL_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_byte(input logic [7:0] no_a, input logic [7:0] no_b);
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == no_a || b == no_b);
        return b;
    endfunction

    task automatic push_item(input logic [7:0] b, input logic last);
        t_req_item it;
        it.byte_in    = b;
        it.chunk_last = last;
        pending_bytes = {pending_bytes, it};
    endtask

    // structured byte, now and then preceded by a NUL-cut chunk of garbage
    task automatic put_byte(input logic [7:0] b);
        int unsigned n;
        if ($urandom_range(0, 39) == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                push_item(CH_NUL, 1'b1);
            end else begin
                push_item(CH_NUL, 1'b0);
                n = $urandom_range(0, 6);
                repeat (n) push_item(8'($urandom_range(0, 255)), 1'b0);
                push_item(8'($urandom_range(0, 255)), 1'b1);
            end
        end
        push_item(b, $urandom_range(0, 7) == 0);
    endtask

    task automatic put_digits(input int unsigned n, input logic nines);
        repeat (n) put_byte(nines ? "9" : 8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic put_noise(input int unsigned n);
        repeat (n) push_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    task automatic put_request_line();
        int unsigned n;
        n = $urandom_range(0, 6);
        repeat (n) put_byte(pick_byte(CH_SP, CH_SP));
        put_byte(CH_SP);
        n = $urandom_range(0, 20);
        repeat (n) put_byte(pick_byte(CH_SP, CH_SP));
        put_byte(CH_SP);
        n = $urandom_range(0, 8);
        repeat (n) put_byte(pick_byte(CH_CR, CH_CR));
        put_byte(CH_CR);
        put_byte(CH_LF);
    endtask

    task automatic put_header_line();
        logic [7:0]  key_txt[$];
        int unsigned kind;
        int unsigned n;
        int unsigned pos;
        kind = $urandom_range(0, 15);
        if (kind < 10) begin
            for (pos = 0; pos < KEY_LEN; pos++)
                key_txt = {key_txt, length_key_char(pos)};
            // near misses: case flip, truncation or one byte too many
            if (kind >= 7) begin
                case ($urandom_range(0, 2))
                    0: begin
                        pos = $urandom_range(0, KEY_LEN - 1);
                        if (length_key_char(pos) == "-")
                            pos++;
                        key_txt[pos] = key_txt[pos] ^ 8'h20;
                    end
                    1: begin
                        n = $urandom_range(1, KEY_LEN - 1);
                        repeat (n) void'(key_txt.pop_back());
                    end
                    default: key_txt = {key_txt, pick_byte(CH_COLON, CH_CR)};
                endcase
            end
        end else if (kind > 10) begin
            n = $urandom_range(1, 12);
            repeat (n) key_txt = {key_txt, pick_byte(CH_COLON, CH_CR)};
        end
        foreach (key_txt[i])
            put_byte(key_txt[i]);
        put_byte(CH_COLON);
        n = $urandom_range(0, 3);
        repeat (n) put_byte(CH_SP);
        case ($urandom_range(0, 7))
            0, 1: put_digits($urandom_range(1, 9), 1'b0);
            2:    put_digits($urandom_range(10, 14), $urandom_range(0, 1) == 1);
            3: begin
                put_byte(CH_PLUS);
                put_digits($urandom_range(1, 10), 1'b0);
            end
            4: begin
                put_byte("-");
                put_digits($urandom_range(1, 5), 1'b0);
            end
            5: begin
                put_digits($urandom_range(1, 6), 1'b0);
                n = $urandom_range(1, 4);
                repeat (n) put_byte(pick_byte(CH_CR, CH_CR));
                put_digits($urandom_range(1, 3), 1'b0);
            end
            6: begin
                n = $urandom_range(1, 10);
                repeat (n) put_byte(pick_byte(CH_CR, CH_SP));
            end
            default: put_byte(CH_CR);   // value that opens with a carriage return
        endcase
        put_byte(CH_CR);
        put_byte(CH_LF);
    endtask

    // ------------------------------------------------------------------------
    // idling: alternating windows with and without bursts, none near the end
    // ------------------------------------------------------------------------
    function automatic logic may_idle();
        return pending_bytes.size() > QUIET_TAIL && (pending_bytes.size() / 256) % 2 == 0;
    endfunction

    // request side driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_hold    <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                expected_tags = {expected_tags, parse_byte(req_ch.data)};
            if (!req_ch.valid || req_ch.ready) begin
                if (send_hold > 0) begin
                    send_hold    <= send_hold - 1;
                    req_ch.valid <= 1'b0;
                end else if (may_idle() && $urandom_range(0, 7) == 0) begin
                    send_hold    <= $urandom_range(0, 10);
                    req_ch.valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= pending_bytes.pop_front();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_bad(input string why, input t_rsp_item want, input t_rsp_item got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t %s: exp byte %h class %0d end %b done %b err %b len %0d",
                     $time, why, want.byte_out, want.byte_class, want.field_end,
                     want.header_done, want.parse_error, want.content_length);
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t %s: got byte %h class %0d end %b done %b err %b len %0d",
                     $time, why, got.byte_out, got.byte_class, got.field_end,
                     got.header_done, got.parse_error, got.content_length);
    endtask

    // result side monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            take_hold    <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_tags.size() == 0) begin
                    report_bad("result with no byte pending", '0, rsp_ch.data);
                end else begin
                    want_rsp = expected_tags.pop_front();
                    if (rsp_ch.data.byte_out       !== want_rsp.byte_out    ||
                        rsp_ch.data.byte_class     !== want_rsp.byte_class  ||
                        rsp_ch.data.field_end      !== want_rsp.field_end   ||
                        rsp_ch.data.header_done    !== want_rsp.header_done ||
                        rsp_ch.data.parse_error    !== want_rsp.parse_error ||
                        rsp_ch.data.content_length !== want_rsp.content_length)
                        report_bad("tag mismatch", want_rsp, rsp_ch.data);
                end
            end
            if (take_hold > 0) begin
                take_hold    <= take_hold - 1;
                rsp_ch.ready <= 1'b0;
            end else if (may_idle() && $urandom_range(0, 7) == 0) begin
                take_hold    <= $urandom_range(0, 10);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        t_ending ending;
        int unsigned roll;

        // directed request line: byte extremes, NUL as chunk end, NUL chunk skip
        push_item(8'h01, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(CH_SP, 1'b1);
        push_item(CH_NUL, 1'b1);
        push_item("/", 1'b0);
        push_item(CH_NUL, 1'b0);
        push_item(CH_SP, 1'b0);
        push_item(CH_CR, 1'b0);
        push_item(CH_NUL, 1'b1);
        push_item(8'h7F, 1'b0);
        push_item(CH_SP, 1'b0);
        push_item("H", 1'b0);
        push_item(CH_CR, 1'b0);
        push_item(CH_LF, 1'b1);
        // length header whose value opens with a carriage return
        for (int p = 0; p < KEY_LEN; p++)
            push_item(length_key_char(p), 1'b0);
        push_item(CH_COLON, 1'b0);
        push_item(CH_CR, 1'b0);
        push_item(CH_CR, 1'b0);
        push_item(CH_LF, 1'b0);

        while (pending_bytes.size() < ITEM_TARGET - BODY_ITEMS)
            put_header_line();

        // a run can only end its header once, so the seed picks how
        roll = $urandom_range(0, 5);
        if (roll < 3)
            ending = END_BODY;
        else
            ending = t_ending'(roll - 2);
        case (ending)
            END_BODY: begin
                put_byte(CH_CR);
                put_byte(CH_LF);
                put_noise(BODY_ITEMS);
            end
            END_BAD_LF: begin
                put_byte("K");
                put_byte(CH_COLON);
                put_byte("1");
                put_byte(CH_CR);
                put_byte(pick_byte(CH_LF, CH_NUL));
                put_noise(BODY_ITEMS / 2);
            end
            END_KEY_CR: begin
                roll = $urandom_range(1, 5);
                repeat (roll) put_byte(pick_byte(CH_COLON, CH_CR));
                put_byte(CH_CR);
                put_noise(BODY_ITEMS / 2);
            end
            default: begin
                put_byte(CH_CR);
                put_byte(pick_byte(CH_LF, CH_NUL));
                put_noise(BODY_ITEMS / 2);
            end
        endcase

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() > 0 || req_ch.valid || expected_tags.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0 && expected_tags.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hrhp_pkg.sv
rtl/hrhp_req_if.sv
rtl/hrhp_rsp_if.sv
rtl/hrhp_digit.sv
rtl/hrhp_core.sv
rtl/http_request_header_parser_unit.sv
test/tb.sv
